// ===== src/chm_pkg.sv =====
// Shared constants, types and control structures of the chained hash map.
`default_nettype none

package chm_pkg;

   // Table geometry.
   localparam int BUCKETS = 64;
   localparam int ENTRIES = 128;

   // Field widths of a request and a response.
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;

   // Derived index and counter widths.
   localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);

   // Bucket selection: a mask for a power-of-two count, else a remainder unit.
   localparam bit BKT_POW2    = ((BUCKETS & (BUCKETS - 1)) == 0);
   localparam int HASH_BITS   = 8;
   localparam int HASH_STEPS  = KEY_W / HASH_BITS;
   localparam int HSTEP_W     = (HASH_STEPS > 1) ? $clog2(HASH_STEPS) : 1;

   // Request command codes; the unused code behaves as a lookup.
   localparam logic [1:0] CMD_LOOKUP  = 2'd0;
   localparam logic [1:0] CMD_ADD     = 2'd1;
   localparam logic [1:0] CMD_REWRITE = 2'd2;

   // Response status codes.
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef logic [KEY_W-1:0]        key_type;
   typedef logic signed [VAL_W-1:0] val_type;
   typedef logic [BKT_W-1:0]        bkt_type;
   typedef logic [SLOT_W-1:0]       slot_type;
   typedef logic [CNT_W-1:0]        cnt_type;

   localparam key_type         BKT_MASK = key_type'(BUCKETS - 1);
   localparam logic [BKT_W:0]  BKT_MOD  = (BKT_W + 1)'(BUCKETS);
   localparam cnt_type         CNT_FULL = cnt_type'(ENTRIES);

   // Chain pointer: a slot index qualified by a valid bit.
   typedef struct packed {
      logic     valid;
      slot_type slot;
   } ptr_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic head_read;
      logic entry_read_head;
      logic entry_read_link;
      logic commit;
      logic hit;
   } chm_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic hash_done;
      logic head_valid;
      logic key_match;
      logic link_valid;
   } chm_stat_type;

endpackage

`default_nettype wire

// ===== src/chm_if.sv =====
// Request and response channel interfaces of the chained hash map.
`default_nettype none

interface chm_req_if;
   import chm_pkg::*;

   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   key_type    key;
   val_type    value;

   modport source (output valid, output cmd, output key, output value, input ready);
   modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

interface chm_rsp_if;
   import chm_pkg::*;

   logic    valid;
   logic    ready;
   logic    found;
   val_type stored_value;
   logic    added;
   logic    status;

   modport source (output valid, output found, output stored_value, output added,
                   output status, input ready);
   modport sink   (input valid, input found, input stored_value, input added,
                   input status, output ready);
endinterface

`default_nettype wire

// ===== src/chm_datapath.sv =====
// Datapath of the chained hash map: bucket hash, head and entry memories, result register.
`default_nettype none

module chm_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  chm_pkg::chm_cmd_type  ctl,
   output chm_pkg::chm_stat_type stat,
   input  logic [1:0]            in_cmd,
   input  chm_pkg::key_type      in_key,
   input  chm_pkg::val_type      in_value,
   output logic                  out_found,
   output chm_pkg::val_type      out_stored_value,
   output logic                  out_added,
   output logic                  out_status
);
   import chm_pkg::*;

   // Captured request.
   logic [1:0] cmd_ff;
   key_type    key_ff;
   val_type    value_ff;

   // Bucket index of the captured key.
   bkt_type    bucket;
   logic       hash_done;

   // Bucket head storage: slots in memory, valid bits in flops.
   slot_type   head_slot_mem [BUCKETS];
   logic [BUCKETS-1:0] head_valid_ff;
   slot_type   head_rd_slot_ff;
   logic       head_rd_valid_ff;

   // Entry pool memories and their registered read data.
   key_type    entry_key_mem    [ENTRIES];
   val_type    entry_record_mem [ENTRIES];
   ptr_type    entry_link_mem   [ENTRIES];
   key_type    rd_key_ff;
   val_type    rd_record_ff;
   ptr_type    rd_link_ff;
   slot_type   rd_slot_ff;
   slot_type   rd_addr;
   logic       rd_en;

   // Pool fill and update decisions.
   cnt_type    count_ff;
   slot_type   ins_slot;
   logic       full;
   logic       insert_due;
   logic       do_insert;
   logic       do_update;
   slot_type   rec_waddr;

   // Result register.
   logic       found_ff;
   val_type    stored_ff;
   logic       added_ff;
   logic       status_ff;

   // Capture the request when it is accepted.
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= in_cmd;
         key_ff   <= in_key;
         value_ff <= in_value;
      end
   end

   // Bucket selection.
   generate
      if (BKT_POW2) begin : g_mask
         assign bucket    = bkt_type'(key_ff & BKT_MASK);
         assign hash_done = 1'b1;
      end else begin : g_rem
         // Remainder by restoring reduction, a byte of the key per cycle.
         bkt_type          rem_ff;
         bkt_type          rem_in;
         key_type          shift_ff;
         logic [HSTEP_W-1:0] step_ff;
         logic             done_ff;

         always_comb begin
            logic [BKT_W:0] t;
            rem_in = rem_ff;
            for (int i = 0; i < HASH_BITS; i++) begin
               t = {rem_in, shift_ff[KEY_W-1-i]};
               if (t >= BKT_MOD) begin
                  t = t - BKT_MOD;
               end
               rem_in = t[BKT_W-1:0];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b1;
               step_ff <= '0;
            end else if (ctl.load) begin
               done_ff <= 1'b0;
               step_ff <= '0;
            end else if (!done_ff) begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == HSTEP_W'(HASH_STEPS - 1)) begin
                  done_ff <= 1'b1;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (ctl.load) begin
               rem_ff   <= '0;
               shift_ff <= in_key;
            end else if (!done_ff) begin
               rem_ff   <= rem_in;
               shift_ff <= shift_ff << HASH_BITS;
            end
         end

         assign bucket    = rem_ff;
         assign hash_done = done_ff;
      end
   endgenerate

   // Insert and update decisions for the commit cycle.
   assign ins_slot   = count_ff[SLOT_W-1:0];
   assign full       = (count_ff == CNT_FULL);
   assign insert_due = ((cmd_ff == CMD_ADD) || (cmd_ff == CMD_REWRITE)) && !ctl.hit;
   assign do_insert  = ctl.commit && insert_due && !full;
   assign do_update  = ctl.commit && ctl.hit && (cmd_ff == CMD_REWRITE);
   assign rec_waddr  = ctl.hit ? rd_slot_ff : ins_slot;

   // Head memory: read the bucket head, write a new head on insert.
   always_ff @(posedge clock) begin
      if (ctl.head_read) begin
         head_rd_slot_ff <= head_slot_mem[bucket];
      end
      if (do_insert) begin
         head_slot_mem[bucket] <= ins_slot;
      end
   end

   // Head valid bits and the pool fill count are cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= '0;
         count_ff      <= '0;
      end else if (do_insert) begin
         head_valid_ff[bucket] <= 1'b1;
         count_ff              <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.head_read) begin
         head_rd_valid_ff <= head_valid_ff[bucket];
      end
   end

   // Entry reads follow the head pointer first, then the chain links.
   assign rd_en   = ctl.entry_read_head || ctl.entry_read_link;
   assign rd_addr = ctl.entry_read_head ? head_rd_slot_ff : rd_link_ff.slot;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_key_ff    <= entry_key_mem[rd_addr];
         rd_record_ff <= entry_record_mem[rd_addr];
         rd_link_ff   <= entry_link_mem[rd_addr];
         rd_slot_ff   <= rd_addr;
      end
      if (do_insert) begin
         entry_key_mem[ins_slot]  <= key_ff;
         entry_link_mem[ins_slot] <= '{valid: head_rd_valid_ff, slot: head_rd_slot_ff};
      end
      if (do_insert || do_update) begin
         entry_record_mem[rec_waddr] <= value_ff;
      end
   end

   // Response payload, loaded in the commit cycle.
   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         found_ff  <= ctl.hit;
         stored_ff <= ctl.hit ? rd_record_ff : '0;
         added_ff  <= do_insert;
         status_ff <= (insert_due && full) ? STATUS_FULL : STATUS_OK;
      end
   end

   assign stat.hash_done  = hash_done;
   assign stat.head_valid = head_rd_valid_ff;
   assign stat.key_match  = (rd_key_ff == key_ff);
   assign stat.link_valid = rd_link_ff.valid;

   assign out_found        = found_ff;
   assign out_stored_value = stored_ff;
   assign out_added        = added_ff;
   assign out_status       = status_ff;

endmodule

`default_nettype wire

// ===== src/chm_controller.sv =====
// Controller of the chained hash map: sequences hash, head read, chain walk and commit.
`default_nettype none

module chm_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  chm_pkg::chm_stat_type stat,
   output chm_pkg::chm_cmd_type  ctl
);
   import chm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HASH,
      ST_HEAD_CHK,
      ST_ENTRY_CMP,
      ST_COMMIT,
      ST_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      hit_ff;
   logic      hit_in;

   // Next state, hit flag and datapath commands.
   always_comb begin
      state_in = state_ff;
      hit_in   = hit_ff;
      ctl      = '0;
      ctl.hit  = hit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            if (stat.hash_done) begin
               ctl.head_read = 1'b1;
               state_in      = ST_HEAD_CHK;
            end
         end
         ST_HEAD_CHK: begin
            if (stat.head_valid) begin
               ctl.entry_read_head = 1'b1;
               state_in            = ST_ENTRY_CMP;
            end else begin
               hit_in   = 1'b0;
               state_in = ST_COMMIT;
            end
         end
         ST_ENTRY_CMP: begin
            // A match ends the walk; otherwise follow the link or stop at chain end.
            if (stat.key_match) begin
               hit_in   = 1'b1;
               state_in = ST_COMMIT;
            end else if (stat.link_valid) begin
               ctl.entry_read_link = 1'b1;
            end else begin
               hit_in   = 1'b0;
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            ctl.commit = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and hit flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         hit_ff   <= hit_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

`default_nettype wire

// ===== src/chained_hash_map.sv =====
// Top level of the chained hash map: controller, datapath and channel hookup.
//
// Key-to-value map with separate chaining: a request's key selects bucket
// key mod BUCKETS, whose chain of entries from a pool of ENTRIES slots is
// walked one entry per cycle out of the entry memories. A lookup reports
// whether the key is present and its record; add inserts an absent key;
// rewrite inserts or updates. When the pool is full an insert is refused
// with status set. One request is handled at a time: from acceptance to
// response valid it passes the hash, head check, chain walk and commit
// states, the walk reading the chain through the single read port of the
// entry memories; a non-power-of-two bucket count makes the hash state
// wait for the remainder unit. After the response is taken the block is
// ready again in the next cycle. Reset clears all bucket heads and the
// pool count at once; no clearing pass is needed.
`default_nettype none

module chained_hash_map (
   input  logic      clock,
   input  logic      reset,
   chm_req_if.sink   req_chan,
   chm_rsp_if.source rsp_chan
);
   import chm_pkg::*;

   chm_cmd_type  ctl;
   chm_stat_type stat;

   chm_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   chm_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .stat             (stat),
      .in_cmd           (req_chan.cmd),
      .in_key           (req_chan.key),
      .in_value         (req_chan.value),
      .out_found        (rsp_chan.found),
      .out_stored_value (rsp_chan.stored_value),
      .out_added        (rsp_chan.added),
      .out_status       (rsp_chan.status)
   );

endmodule

`default_nettype wire
